// ----- design/assert_macros.svh -----
// assertion macros shared by the rotation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AR3D_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ar3d assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define AR3D_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ar3d assertion failed");

`endif

// ----- design/ar3d_pkg.sv -----
// types, constants and arctangent table for the axis rotation block
package ar3d_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int ANGLE_WIDTH      = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int BAM_W            = 32;
    localparam int TRIG_W           = 32;
    localparam int TRIG_FRAC        = 30;
    localparam int ANG_W            = BAM_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]      trig_t;
    typedef logic signed [ANG_W-1:0]       ang_t;

    localparam trig_t  INV_GAIN  = TRIG_W'(652032874);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    typedef struct packed {
        logic [1:0]             func;
        coord_t                 x_in;
        coord_t                 y_in;
        coord_t                 z_in;
        logic [ANGLE_WIDTH-1:0] angle;
    } req_t;

    typedef struct packed {
        coord_t x_out;
        coord_t y_out;
        coord_t z_out;
    } rsp_t;

    typedef struct packed {
        logic [1:0] func;
        coord_t     x;
        coord_t     y;
        coord_t     z;
    } pass_t;

    typedef struct packed {
        trig_t      cx;
        trig_t      cy;
        ang_t       cz;
        logic [1:0] quad;
        pass_t      pass;
    } cell_t;

    function automatic ang_t atan_val(input logic [4:0] idx);
        ang_t v;
        case (idx)
            5'd0:    v = ANG_W'(536870912);
            5'd1:    v = ANG_W'(316933406);
            5'd2:    v = ANG_W'(167458907);
            5'd3:    v = ANG_W'(85004756);
            5'd4:    v = ANG_W'(42667331);
            5'd5:    v = ANG_W'(21354465);
            5'd6:    v = ANG_W'(10679838);
            5'd7:    v = ANG_W'(5340245);
            5'd8:    v = ANG_W'(2670163);
            5'd9:    v = ANG_W'(1335087);
            5'd10:   v = ANG_W'(667544);
            5'd11:   v = ANG_W'(333772);
            5'd12:   v = ANG_W'(166886);
            5'd13:   v = ANG_W'(83443);
            5'd14:   v = ANG_W'(41722);
            5'd15:   v = ANG_W'(20861);
            5'd16:   v = ANG_W'(10430);
            5'd17:   v = ANG_W'(5215);
            5'd18:   v = ANG_W'(2608);
            5'd19:   v = ANG_W'(1304);
            5'd20:   v = ANG_W'(652);
            5'd21:   v = ANG_W'(326);
            5'd22:   v = ANG_W'(163);
            5'd23:   v = ANG_W'(81);
            5'd24:   v = ANG_W'(41);
            5'd25:   v = ANG_W'(20);
            5'd26:   v = ANG_W'(10);
            5'd27:   v = ANG_W'(5);
            5'd28:   v = ANG_W'(3);
            5'd29:   v = ANG_W'(1);
            5'd30:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/ar3d_cordic_cell.sv -----
// one cordic micro-rotation cell of the sine/cosine chain
module ar3d_cordic_cell
    import ar3d_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  src_valid,
    input  cell_t src,
    output logic  dst_valid,
    output cell_t dst
);

    cell_t dst_reg;
    cell_t dst_next;
    logic  valid_reg;
    trig_t dx;
    trig_t dy;
    ang_t  step_ang;

    assign dx       = src.cy >>> STEP;
    assign dy       = src.cx >>> STEP;
    assign step_ang = atan_val(5'(STEP));

    always_comb
    begin
        dst_next = src;
        if (!src.cz[ANG_W-1])
        begin
            dst_next.cx = src.cx - dx;
            dst_next.cy = src.cy + dy;
            dst_next.cz = src.cz - step_ang;
        end
        else
        begin
            dst_next.cx = src.cx + dx;
            dst_next.cy = src.cy - dy;
            dst_next.cz = src.cz + step_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_reg <= dst_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst       = dst_reg;

endmodule

// ----- design/ar3d_mac_lane.sv -----
// rounded, saturated a*c + b*s lane in three stages
module ar3d_mac_lane
    import ar3d_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t a,
    input  trig_t  c,
    input  coord_t b,
    input  trig_t  s,
    output coord_t res
);

    localparam int LO_W = COORD_WIDTH / 2;
    localparam int HI_W = COORD_WIDTH - LO_W;
    localparam int PH_W = HI_W + TRIG_W;
    localparam int PL_W = LO_W + 1 + TRIG_W;
    localparam int SH_W = PH_W + 1;
    localparam int SL_W = PL_W + 2;
    localparam int T_W  = COORD_WIDTH + TRIG_W + 2;
    localparam int Q_W  = T_W - TRIG_FRAC;
    localparam logic signed [SL_W-1:0] ROUND = SL_W'(64'd1 << (TRIG_FRAC - 1));

    logic signed [HI_W-1:0]  ah;
    logic signed [HI_W-1:0]  bh;
    logic signed [LO_W:0]    al;
    logic signed [LO_W:0]    bl;
    logic signed [PH_W-1:0]  ahc_next;
    logic signed [PH_W-1:0]  bhs_next;
    logic signed [PL_W-1:0]  alc_next;
    logic signed [PL_W-1:0]  bls_next;
    logic signed [PH_W-1:0]  ahc_reg;
    logic signed [PH_W-1:0]  bhs_reg;
    logic signed [PL_W-1:0]  alc_reg;
    logic signed [PL_W-1:0]  bls_reg;
    logic signed [SH_W-1:0]  hi_next;
    logic signed [SL_W-1:0]  lo_next;
    logic signed [SH_W-1:0]  hi_reg;
    logic signed [SL_W-1:0]  lo_reg;
    logic signed [T_W-1:0]   tot;
    logic signed [Q_W-1:0]   q;
    logic [Q_W-COORD_WIDTH:0] top;
    logic                    ovf;
    coord_t                  res_next;
    coord_t                  res_reg;

    assign ah = a[COORD_WIDTH-1:LO_W];
    assign bh = b[COORD_WIDTH-1:LO_W];
    assign al = {1'b0, a[LO_W-1:0]};
    assign bl = {1'b0, b[LO_W-1:0]};

    // split products
    always_comb
    begin
        ahc_next = PH_W'(ah) * PH_W'(c);
        bhs_next = PH_W'(bh) * PH_W'(s);
        alc_next = PL_W'(al) * PL_W'(c);
        bls_next = PL_W'(bl) * PL_W'(s);
    end

    // partial sums with rounding bias
    always_comb
    begin
        hi_next = SH_W'(ahc_reg) + SH_W'(bhs_reg);
        lo_next = SL_W'(alc_reg) + SL_W'(bls_reg) + ROUND;
    end

    // recombine, scale back and saturate
    always_comb
    begin
        tot = (T_W'(hi_reg) <<< LO_W) + T_W'(lo_reg);
        q   = tot[T_W-1:TRIG_FRAC];
        top = q[Q_W-1:COORD_WIDTH-1];
        ovf = !((&top) || !(|top));
        if (ovf)
        begin
            res_next = q[Q_W-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            res_next = q[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ahc_reg <= ahc_next;
            bhs_reg <= bhs_next;
            alc_reg <= alc_next;
            bls_reg <= bls_next;
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- design/ar3d_skid.sv -----
// two-entry output register with skid slot
`include "assert_macros.svh"

module ar3d_skid
    import ar3d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  rsp_t up,
    output logic full,
    output logic dn_valid,
    output rsp_t dn,
    input  logic dn_stall
);

    logic dn_valid_reg;
    logic dn_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t dn_reg;
    rsp_t skid_reg;
    logic take_up;
    logic dn_free;

    assign take_up = up_valid && !skid_valid_reg;
    assign dn_free = !dn_valid_reg || !dn_stall;

    always_comb
    begin
        dn_valid_next   = dn_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (dn_free)
        begin
            if (skid_valid_reg)
            begin
                dn_valid_next   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                dn_valid_next = take_up;
            end
        end
        else if (take_up)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            dn_valid_reg   <= dn_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dn_free)
        begin
            if (skid_valid_reg)
            begin
                dn_reg <= skid_reg;
            end
            else if (take_up)
            begin
                dn_reg <= up;
            end
        end
        else if (take_up)
        begin
            skid_reg <= up;
        end
    end

    assign full     = skid_valid_reg;
    assign dn_valid = dn_valid_reg;
    assign dn       = dn_reg;

    `AR3D_ASSERT_IMP(a_full_has_out, full, dn_valid)
    `AR3D_ASSERT_NXT(a_skid_drains, full && !dn_stall, !full && dn_valid)
    `AR3D_ASSERT_NXT(a_skid_fills, dn_valid && dn_stall && up_valid && !full, full && dn_valid)

endmodule

// ----- design/axis_rotation_3d.sv -----
// top level: rotates a point about one coordinate axis
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (func, x_in, y_in, z_in, angle)
//  result  | rsp_valid | rsp_stall | rsp (x_out, y_out, z_out)
//
// one request per cycle while req_stall is low
// the pipeline is the cordic cell chain, one select stage and the three-stage product lanes
// reset clears only the valid bits; no clearing pass
// req_stall is registered and rises only while the skid slot holds a stalled result
// the whole pipeline holds while req_stall is high

module axis_rotation_3d
    import ar3d_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                  en;
    logic                  full;
    logic [BAM_W-1:0]      a32;
    cell_t                 seed;
    cell_t                 chain [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] vchain;
    cell_t                 last;

    trig_t  nx;
    trig_t  ny;
    trig_t  cs;
    trig_t  sn;
    trig_t  nsn;
    coord_t a0_next;
    coord_t b0_next;
    coord_t a1_next;
    coord_t b1_next;
    trig_t  c0_next;
    trig_t  s0_next;
    trig_t  c1_next;
    trig_t  s1_next;
    coord_t a0_reg;
    coord_t b0_reg;
    coord_t a1_reg;
    coord_t b1_reg;
    trig_t  c0_reg;
    trig_t  s0_reg;
    trig_t  c1_reg;
    trig_t  s1_reg;
    logic   sel_valid_reg;
    pass_t  sel_pass_reg;

    logic [2:0] lv_reg;
    pass_t      pd_reg [3];
    coord_t     r0;
    coord_t     r1;
    rsp_t       up;

    assign en        = !full;
    assign req_stall = full;

    // cordic seed from the request
    always_comb
    begin
        a32            = {req.angle, {(BAM_W-ANGLE_WIDTH){1'b0}}};
        seed.cx        = INV_GAIN;
        seed.cy        = '0;
        seed.cz        = ANG_W'(a32[BAM_W-3:0]);
        seed.quad      = a32[BAM_W-1:BAM_W-2];
        seed.pass.func = req.func;
        seed.pass.x    = req.x_in;
        seed.pass.y    = req.y_in;
        seed.pass.z    = req.z_in;
    end

    assign chain[0]  = seed;
    assign vchain[0] = req_valid;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        ar3d_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (vchain[g]),
            .src       (chain[g]),
            .dst_valid (vchain[g+1]),
            .dst       (chain[g+1])
        );
    end

    assign last = chain[CORDIC_STEPS];
    assign nx   = -last.cx;
    assign ny   = -last.cy;

    // quadrant fold
    always_comb
    begin
        case (last.quad)
            QUAD_I:
            begin
                cs  = last.cx;
                sn  = last.cy;
                nsn = ny;
            end
            QUAD_II:
            begin
                cs  = ny;
                sn  = last.cx;
                nsn = nx;
            end
            QUAD_III:
            begin
                cs  = nx;
                sn  = ny;
                nsn = last.cy;
            end
            default:
            begin
                cs  = last.cy;
                sn  = nx;
                nsn = last.cx;
            end
        endcase
    end

    // lane operands per axis
    always_comb
    begin
        case (last.pass.func)
            AXIS_X:
            begin
                a0_next = last.pass.y;
                c0_next = cs;
                b0_next = last.pass.z;
                s0_next = sn;
                a1_next = last.pass.z;
                c1_next = cs;
                b1_next = last.pass.y;
                s1_next = nsn;
            end
            AXIS_Y:
            begin
                a0_next = last.pass.x;
                c0_next = cs;
                b0_next = last.pass.z;
                s0_next = nsn;
                a1_next = last.pass.x;
                c1_next = sn;
                b1_next = last.pass.z;
                s1_next = cs;
            end
            AXIS_Z:
            begin
                a0_next = last.pass.x;
                c0_next = cs;
                b0_next = last.pass.y;
                s0_next = sn;
                a1_next = last.pass.y;
                c1_next = cs;
                b1_next = last.pass.x;
                s1_next = nsn;
            end
            default:
            begin
                a0_next = '0;
                c0_next = '0;
                b0_next = '0;
                s0_next = '0;
                a1_next = '0;
                c1_next = '0;
                b1_next = '0;
                s1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            lv_reg        <= '0;
        end
        else if (en)
        begin
            sel_valid_reg <= vchain[CORDIC_STEPS];
            lv_reg        <= {lv_reg[1:0], sel_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg       <= a0_next;
            b0_reg       <= b0_next;
            c0_reg       <= c0_next;
            s0_reg       <= s0_next;
            a1_reg       <= a1_next;
            b1_reg       <= b1_next;
            c1_reg       <= c1_next;
            s1_reg       <= s1_next;
            sel_pass_reg <= last.pass;
            pd_reg[0]    <= sel_pass_reg;
            pd_reg[1]    <= pd_reg[0];
            pd_reg[2]    <= pd_reg[1];
        end
    end

    ar3d_mac_lane u_lane0 (
        .clk (clk),
        .en  (en),
        .a   (a0_reg),
        .c   (c0_reg),
        .b   (b0_reg),
        .s   (s0_reg),
        .res (r0)
    );

    ar3d_mac_lane u_lane1 (
        .clk (clk),
        .en  (en),
        .a   (a1_reg),
        .c   (c1_reg),
        .b   (b1_reg),
        .s   (s1_reg),
        .res (r1)
    );

    // place lane results, axis coordinate passes through
    always_comb
    begin
        case (pd_reg[2].func)
            AXIS_X:
            begin
                up.x_out = pd_reg[2].x;
                up.y_out = r0;
                up.z_out = r1;
            end
            AXIS_Y:
            begin
                up.x_out = r0;
                up.y_out = pd_reg[2].y;
                up.z_out = r1;
            end
            AXIS_Z:
            begin
                up.x_out = r0;
                up.y_out = r1;
                up.z_out = pd_reg[2].z;
            end
            default:
            begin
                up.x_out = pd_reg[2].x;
                up.y_out = pd_reg[2].y;
                up.z_out = pd_reg[2].z;
            end
        endcase
    end

    ar3d_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lv_reg[2]),
        .up       (up),
        .full     (full),
        .dn_valid (rsp_valid),
        .dn       (rsp),
        .dn_stall (rsp_stall)
    );

endmodule
